// ===== hdl/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants for the bounded stack with dump.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int CAP_W     = 7;
    localparam int ACT_W     = 3;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH      = 3'd0,
        ACT_POP       = 3'd1,
        ACT_DUMP_UP   = 3'd2,
        ACT_DUMP_DOWN = 3'd3,
        ACT_SHOW      = 3'd4
    } action_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef enum logic [1:0] {
        WALK_UP,
        WALK_DOWN,
        WALK_TOP
    } walk_mode_t;

    // controller -> datapath
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       start;
        walk_mode_t mode;
        logic       step;
        logic       load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic walk_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/bsd_ram.sv =====
// ----------------------------------------------------------------------------
// bsd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bsd_datapath.sv =====
// ----------------------------------------------------------------------------
// bsd_datapath
// Entry count, capacity register, entry RAM, walk pointer and output register.
// ----------------------------------------------------------------------------
module bsd_datapath
    import bsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         capacity,
    input  logic signed [WORD_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] data,
    output logic                     last,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     count_reg, count_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     remain_reg, remain_next;
    logic              down_reg, down_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;

    logic [CW-1:0]     top_idx;
    logic [AW-1:0]     start_addr;
    logic [AW-1:0]     step_addr;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic [WORD_W-1:0] rd_data;

    assign cfg_ready = 1'b1;

    assign top_idx    = count_reg - 1'b1;
    assign start_addr = (cmd.mode == WALK_UP) ? '0 : top_idx[AW-1:0];
    assign step_addr  = down_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
    assign rd_addr    = cmd.start ? start_addr : step_addr;
    assign rd_en      = cmd.start | cmd.step;

    bsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata (value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // full when count reaches capacity or the physical depth
    assign status.empty     = (count_reg == '0);
    assign status.full      = !(CAP_W'(count_reg) < cap_reg) || (count_reg == CW'(DEPTH));
    assign status.walk_last = (remain_reg == CW'(1));
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        down_next   = down_reg;
        if (cmd.start)
        begin
            ptr_next    = start_addr;
            remain_next = (cmd.mode == WALK_TOP) ? CW'(1) : count_reg;
            down_next   = (cmd.mode != WALK_UP);
        end
        else if (cmd.step)
        begin
            ptr_next    = step_addr;
            remain_next = remain_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            data_next      = rd_data;
            last_next      = status.walk_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        down_reg <= down_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not advance count");

    a_step_remain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> remain_reg > CW'(1))
        else $error("walk stepped past final entry");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> status.out_free)
        else $error("output register overwritten before transfer");

endmodule

// ===== hdl/bsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsd_ctrl
// Controller: decodes actions and sequences the read walk for show and dumps.
// ----------------------------------------------------------------------------
module bsd_ctrl
    import bsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ACT_W-1:0] action,
    input  dp_status_t       status,
    output dp_cmd_t          cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !status.empty &&
                    (action == ACT_DUMP_UP || action == ACT_DUMP_DOWN ||
                     action == ACT_SHOW))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.out_free && status.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        cmd.mode  = WALK_UP;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (action)
                        ACT_PUSH:
                        begin
                            cmd.push = !status.full;
                        end
                        ACT_POP:
                        begin
                            cmd.pop = !status.empty;
                        end
                        ACT_DUMP_UP:
                        begin
                            cmd.start = !status.empty;
                            cmd.mode  = WALK_UP;
                        end
                        ACT_DUMP_DOWN:
                        begin
                            cmd.start = !status.empty;
                            cmd.mode  = WALK_DOWN;
                        end
                        ACT_SHOW:
                        begin
                            cmd.start = !status.empty;
                            cmd.mode  = WALK_TOP;
                        end
                        default:
                        begin
                            // unused codes are consumed with no effect
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.step = !status.walk_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/bounded_stack_with_dump.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_dump
// Push and pop update the registered entry count; input stays open for the next item.
// Show and dumps: each result passes through the registered RAM read and then the output register,
// then one result per cycle while out_ready is high.
// Input is held off during a walk; it reopens once the final result is loaded.
// Reset: count 0, capacity 64, output empty; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_stack_with_dump
    import bsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [WORD_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] data,
    output logic                     last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         capacity
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    bsd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .capacity  (capacity),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data      (data),
        .last      (last),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
